@@ rtl/bfa_pkg.sv @@
package bfa_pkg;

    // table geometry
    localparam int NUM_BLOCKS = 16;
    localparam int BLK_W      = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int CNT_W      = $clog2(NUM_BLOCKS + 1);

    // field widths
    localparam int IDX_W  = 4;
    localparam int SIZE_W = 16;
    localparam int TOT_W  = SIZE_W + BLK_W;
    localparam int XIDX_W = (IDX_W > BLK_W) ? IDX_W : BLK_W;

    // opcodes
    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_REQUEST = 1'b1;

    // one table entry as stored in memory
    typedef struct packed {
        logic              reserved;
        logic              full;
        logic [SIZE_W-1:0] size;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // one result
    typedef struct packed {
        logic              granted;
        logic [IDX_W-1:0]  chosen_block;
        logic [SIZE_W-1:0] leftover;
        logic              external_fragment;
    } result_t;

endpackage

@@ rtl/bfa_if.sv @@
interface bfa_req_if;
    import bfa_pkg::*;

    logic              valid;
    logic              ready;
    logic              opcode;
    logic [IDX_W-1:0]  block_index;
    logic              block_reserved;
    logic [SIZE_W-1:0] size;

    modport source (output valid, opcode, block_index, block_reserved, size, input ready);
    modport sink   (input valid, opcode, block_index, block_reserved, size, output ready);
endinterface

interface bfa_res_if;
    import bfa_pkg::*;

    logic              valid;
    logic              ready;
    logic              granted;
    logic [IDX_W-1:0]  chosen_block;
    logic [SIZE_W-1:0] leftover;
    logic              external_fragment;

    modport source (output valid, granted, chosen_block, leftover, external_fragment,
                    input ready);
    modport sink   (input valid, granted, chosen_block, leftover, external_fragment,
                    output ready);
endinterface

@@ rtl/best_fit_block_allocator_unit.sv @@
// Best-fit block allocator over a table of NUM_BLOCKS entries.
// Channel req carries one request: opcode 0 loads an entry (size and
// reserved mark, full mark cleared), opcode 1 asks for size units.
// Channel res returns exactly one result per request: granted, the chosen
// entry and its leftover size, or on no fit the external_fragment flag if
// the unreserved entry sizes together would cover the request. A load goes
// from acceptance straight to the result hand-off, and the next request can
// be accepted once the block is back in idle. An allocation scans the table
// memory one entry a cycle through its single read port, and its result
// follows the scan, the registered read of the last entry, the write-back
// of the chosen entry and the result hand-off. The block then returns to
// idle before it accepts the next request.
// One request is in progress at a time; req.ready is high while idle, also
// while an earlier result still waits in the output register.
// If res.ready is low when a new result is finished, the block holds it
// internally and goes back to idle only once the output register is free.
// Reset clears every entry to size zero, free and not full through per-entry
// valid bits, so no clearing pass is needed; the block is ready right away.
module best_fit_block_allocator_unit (
    input  logic      clk,
    input  logic      rst_n,
    bfa_req_if.sink   req,
    bfa_res_if.source res
);
    import bfa_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_WB   = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [NUM_BLOCKS-1:0] ent_vld_reg;

    logic              rd_vld_reg;
    logic [BLK_W-1:0]  rd_idx_reg;
    logic              rd_ent_vld_reg;

    logic              found_reg;
    logic [BLK_W-1:0]  best_reg;
    logic [SIZE_W-1:0] best_left_reg;
    logic [TOT_W-1:0]  total_reg;
    logic [SIZE_W-1:0] req_size_reg;

    result_t           pend_reg;
    result_t           out_reg;
    logic              out_vld_reg;

    logic              in_acc;
    logic              load_acc;
    logic              ld_in_range;
    logic [XIDX_W-1:0] ld_idx_x;
    logic              issue;
    logic              last_eval;
    logic              out_free;

    logic              wr_en;
    logic [BLK_W-1:0]  wr_addr;
    entry_t            wr_data;
    entry_t            rd_data;

    logic [SIZE_W-1:0] ev_size;
    logic              ev_rsv;
    logic              ev_full;
    logic              ev_fit;
    logic [SIZE_W-1:0] ev_left;
    logic              ev_take;

    // handshake decode
    assign req.ready   = (state_reg == ST_IDLE);
    assign in_acc      = req.valid && req.ready;
    assign load_acc    = in_acc && (req.opcode == OP_LOAD);
    assign ld_idx_x    = XIDX_W'(req.block_index);
    assign ld_in_range = ({1'b0, ld_idx_x} < (XIDX_W + 1)'(NUM_BLOCKS));
    assign issue       = (state_reg == ST_SCAN) && (cnt_reg < CNT_W'(NUM_BLOCKS));
    assign last_eval   = rd_vld_reg && (rd_idx_reg == BLK_W'(NUM_BLOCKS - 1));
    assign out_free    = !out_vld_reg || res.ready;

    // table memory write port: load or write-back of the chosen entry
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = ld_idx_x[BLK_W-1:0];
        wr_data = '{reserved: req.block_reserved, full: 1'b0, size: req.size};
        if (load_acc && ld_in_range)
        begin
            wr_en = 1'b1;
        end
        else if ((state_reg == ST_WB) && found_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = best_reg;
            wr_data = '{reserved: 1'b0, full: (best_left_reg == '0), size: best_left_reg};
        end
    end

    bfa_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_BLOCKS)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (issue),
        .rd_addr (cnt_reg[BLK_W-1:0]),
        .rd_data (rd_data)
    );

    // evaluate the entry read last cycle; unwritten entries read as zero
    always_comb
    begin
        ev_size = rd_ent_vld_reg ? rd_data.size     : '0;
        ev_rsv  = rd_ent_vld_reg ? rd_data.reserved : 1'b0;
        ev_full = rd_ent_vld_reg ? rd_data.full     : 1'b0;
        ev_fit  = rd_vld_reg && !ev_rsv && !ev_full && (ev_size >= req_size_reg);
        ev_left = ev_size - req_size_reg;
        ev_take = ev_fit && (!found_reg || (ev_left < best_left_reg));
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                cnt_next = '0;
                if (in_acc)
                begin
                    state_next = (req.opcode == OP_REQUEST) ? ST_SCAN : ST_FIN;
                end
            end
            ST_SCAN:
            begin
                if (issue)
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
                if (last_eval)
                begin
                    state_next = ST_WB;
                end
            end
            ST_WB:
            begin
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            rd_vld_reg  <= 1'b0;
            ent_vld_reg <= '0;
            out_vld_reg <= 1'b0;
            found_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            rd_vld_reg <= issue;
            if (wr_en)
            begin
                ent_vld_reg[wr_addr] <= 1'b1;
            end
            if ((state_reg == ST_FIN) && out_free)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_vld_reg <= 1'b0;
            end
            if (in_acc)
            begin
                found_reg <= 1'b0;
            end
            else if (ev_take)
            begin
                found_reg <= 1'b1;
            end
        end
    end

    // scan datapath
    always_ff @(posedge clk)
    begin
        rd_idx_reg     <= cnt_reg[BLK_W-1:0];
        rd_ent_vld_reg <= ent_vld_reg[cnt_reg[BLK_W-1:0]];
        if (in_acc)
        begin
            req_size_reg <= req.size;
            total_reg    <= '0;
        end
        else if (rd_vld_reg && !ev_rsv)
        begin
            total_reg <= total_reg + TOT_W'(ev_size);
        end
        if (ev_take)
        begin
            best_reg      <= rd_idx_reg;
            best_left_reg <= ev_left;
        end
    end

    // pending result and output register
    always_ff @(posedge clk)
    begin
        if (load_acc)
        begin
            pend_reg <= '0;
        end
        else if (state_reg == ST_WB)
        begin
            pend_reg.granted           <= found_reg;
            pend_reg.chosen_block      <= found_reg ? IDX_W'(best_reg) : '0;
            pend_reg.leftover          <= found_reg ? best_left_reg : '0;
            pend_reg.external_fragment <= !found_reg &&
                                          (total_reg >= TOT_W'(req_size_reg));
        end
        if ((state_reg == ST_FIN) && out_free)
        begin
            out_reg <= pend_reg;
        end
    end

    assign res.valid             = out_vld_reg;
    assign res.granted           = out_reg.granted;
    assign res.chosen_block      = out_reg.chosen_block;
    assign res.leftover          = out_reg.leftover;
    assign res.external_fragment = out_reg.external_fragment;

    // no table write while the scan reads it
    a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> !wr_en)
        else $error("table written during scan");

    // a grant never also flags fragmentation
    a_grant_no_frag: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.granted |-> !res.external_fragment)
        else $error("grant with fragmentation flag");

    // read data only shows up after a scan read was issued
    a_read_from_scan: assert property (@(posedge clk) disable iff (!rst_n)
        rd_vld_reg |-> $past(state_reg == ST_SCAN))
        else $error("evaluation without scan read");

    // write-back is followed directly by the hand-off
    a_wb_to_fin: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WB) |=> (state_reg == ST_FIN))
        else $error("write-back not followed by hand-off");

    // a new result is only loaded when the output slot is free
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN) && out_vld_reg && !res.ready |=> (state_reg == ST_FIN))
        else $error("result left hand-off while output stalled");

endmodule

@@ rtl/bfa_ram.sv @@
module bfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [$clog2(DEPTH)-1:0]   wr_addr,
    input  logic [WIDTH-1:0]           wr_data,
    input  logic                       rd_en,
    input  logic [$clog2(DEPTH)-1:0]   rd_addr,
    output logic [WIDTH-1:0]           rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
